/* hw/rtl/julia_escape_time_assert.svh */
// Assertion macros shared by the escape-time checker.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef JULIA_ESCAPE_TIME_ASSERT_SVH
`define JULIA_ESCAPE_TIME_ASSERT_SVH

// Condition that implies another in the same cycle.
`define JET_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that implies a sequence starting in the next cycle.
`define JET_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/jet_pkg.sv */
// Shared types, constants and helpers for the Julia escape-time engine.
// No dependencies; every other .sv file imports this package.
`default_nettype none

package jet_pkg;

	// field widths
	localparam int PIX_W     = 10;
	localparam int ITER_W    = 9;
	localparam int ITER_MAX  = 511;
	localparam int Q_W       = 32;
	localparam int UQ_W      = 31;
	localparam int PROD_W    = 64;
	localparam int CFG_IDX_W = 3;

	// Q4.28 fraction bits, and the coordinate map: pos * 2^30 / size - 2^29
	localparam int FRAC      = 28;
	localparam int MAP_SHIFT = 30;
	localparam int MAP_HALF  = 536870912;

	// default top-level parameters
	localparam int DEF_IMG_WIDTH  = 1024;
	localparam int DEF_IMG_HEIGHT = 1024;
	localparam int DEF_ITER_CAP   = 256;

	// register reset values
	localparam logic [UQ_W-1:0] ZOOM_RST = 31'd268435456;
	localparam logic [UQ_W-1:0] ESC_RST  = 31'd1073741824;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C_RE      = 3'd0,
		REG_C_IM      = 3'd1,
		REG_ZOOM      = 3'd2,
		REG_PAN_RE    = 3'd3,
		REG_PAN_IM    = 3'd4,
		REG_ESC_LIMIT = 3'd5
	} jet_reg_t;

	typedef logic signed [Q_W-1:0]    q_word_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	// saturation to signed 32 bits from a wider intermediate
	localparam int SAT_W = 48;
	localparam logic signed [SAT_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
	localparam logic signed [SAT_W-1:0] SAT_LO = 48'shFFFF_8000_0000;

	function automatic q_word_t sat32(input logic signed [SAT_W-1:0] v);
		q_word_t r;
		if (v > SAT_HI) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/jet_if.sv */
// Valid/ready channel interfaces: pixel input, result output, register writes.
// Depends on jet_pkg for field widths.
`default_nettype none

interface jet_pix_if import jet_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pix_col;
	logic [PIX_W-1:0] pix_row;

	modport source (output valid, output pix_col, output pix_row, input ready);
	modport sink   (input valid, input pix_col, input pix_row, output ready);
endinterface

interface jet_res_if import jet_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  out_col;
	logic [PIX_W-1:0]  out_row;
	logic [ITER_W-1:0] iter_count;

	modport source (output valid, output out_col, output out_row, output iter_count,
		input ready);
	modport sink   (input valid, input out_col, input out_row, input iter_count,
		output ready);
endinterface

interface jet_cfg_if import jet_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [Q_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/jet_div.sv */
// Position scaling for a fixed divisor: floor((pos << MAP_SHIFT) / DIVISOR).
// Whole part by one constant product, remainder share by reciprocal multiply;
// two register stages; depends on jet_pkg.
`default_nettype none

module jet_div import jet_pkg::*; #(
	parameter int DIVISOR = DEF_IMG_WIDTH,
	parameter int PW      = PIX_W,
	parameter int QW      = PIX_W + MAP_SHIFT
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [PW-1:0] pos,
	output logic [QW-1:0] quo
);

	// 2^MAP_SHIFT = WHOLE * DIVISOR + REM_PART
	localparam int     DB       = $clog2(DIVISOR);
	localparam longint WHOLE    = (longint'(1) << MAP_SHIFT) / DIVISOR;
	localparam longint REM_PART = (longint'(1) << MAP_SHIFT) % DIVISOR;

	// pos * REM_PART < 2^(PW+DB), so a shift of PW + 2*DB gives an exact floor
	localparam int     XW        = PW + DB;
	localparam int     RW        = PW + DB + 1;
	localparam int     PRW       = XW + RW;
	localparam int     RCP_SHIFT = PW + 2 * DB;
	localparam longint RCP       = ((longint'(1) << RCP_SHIFT) + DIVISOR - 1) / DIVISOR;

	logic [QW-1:0]  whole_q;
	logic [XW-1:0]  part_q;
	logic [QW-1:0]  quo_q;
	logic [PRW-1:0] part_prod;

	// remainder share: floor(part / DIVISOR)
	assign part_prod = {{RW{1'b0}}, part_q} * {{XW{1'b0}}, RW'(RCP)};

	// load splits the position, step combines the two shares
	always_ff @(posedge clk) begin
		if (load) begin
			whole_q <= QW'(pos) * QW'(WHOLE);
			part_q  <= XW'(pos) * XW'(REM_PART);
		end
		if (step) begin
			quo_q <= whole_q + QW'(part_prod[PRW-1:RCP_SHIFT]);
		end
	end

	assign quo = quo_q;

endmodule

`default_nettype wire

/* hw/rtl/jet_cmul.sv */
// Shared multiplier bank: complex square of z, or both map coordinates times zoom.
// Three 32x32 signed multipliers with registered products; depends on jet_pkg.
`default_nettype none

module jet_cmul import jet_pkg::*; (
	input  logic            clk,
	input  logic            map_sel,
	input  q_word_t         a_re,
	input  q_word_t         a_im,
	input  logic [UQ_W-1:0] k,
	output prod_t           p_rr,
	output prod_t           p_ii,
	output prod_t           p_ri
);

	q_word_t b_re;
	q_word_t b_im;
	prod_t   rr_q;
	prod_t   ii_q;
	prod_t   ri_q;

	// second operand: zoom when mapping, else the value itself (squares)
	assign b_re = map_sel ? $signed({1'b0, k}) : a_re;
	assign b_im = map_sel ? $signed({1'b0, k}) : a_im;

	always_ff @(posedge clk) begin
		rr_q <= PROD_W'(a_re) * PROD_W'(b_re);
		ii_q <= PROD_W'(a_im) * PROD_W'(b_im);
		ri_q <= PROD_W'(a_re) * PROD_W'(a_im);
	end

	assign p_rr = rr_q;
	assign p_ii = ii_q;
	assign p_ri = ri_q;

endmodule

`default_nettype wire

/* hw/rtl/julia_escape_time.sv */
// Julia set escape-time engine, top level. Uses jet_pkg, jet_if, jet_div, jet_cmul.
// Takes pixel words, returns the position with its iteration count.
`default_nettype none

// One pixel word is taken at a time; pix.ready is high only while the engine is idle.
// The pixel position is first mapped to a Q4.28 start point by two constant-divisor
// units (reciprocal multiply), then scaled by zoom and offset by pan. Each iteration
// of z = z^2 + c passes through the shared multiplier bank in ST_MUL, which registers
// the three products, and then ST_UPD, which tests |z|^2 and updates z.
// A finished pixel waits in ST_UPD while the output register still holds an untaken
// word; the engine returns to idle, ready for the next pixel, in the same cycle as
// its result word turns valid.
// The result sits in an output register, so the next pixel is accepted while it
// waits. Register writes are taken every cycle and belong in idle periods only.

module julia_escape_time import jet_pkg::*; #(
	parameter int IMG_WIDTH  = DEF_IMG_WIDTH,
	parameter int IMG_HEIGHT = DEF_IMG_HEIGHT,
	parameter int ITER_CAP   = DEF_ITER_CAP
) (
	input  logic     clk,
	input  logic     arst_n,
	jet_pix_if.sink  pix,
	jet_res_if.source res,
	jet_cfg_if.sink  cfg
);

	localparam int QW    = PIX_W + MAP_SHIFT;
	localparam int MW    = QW + 1;
	localparam int NW    = $clog2(ITER_CAP + 1);
	localparam int CW    = (NW > ITER_W) ? NW : ITER_W;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_DIV     = 6'b000010,
		ST_MAP_MUL = 6'b000100,
		ST_MAP_ADD = 6'b001000,
		ST_MUL     = 6'b010000,
		ST_UPD     = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [NW-1:0]     n_q;
	q_word_t           zr_q, zi_q;
	logic [PIX_W-1:0]  col_q, row_q;

	q_word_t           c_re_q, c_im_q, pan_re_q, pan_im_q;
	logic [UQ_W-1:0]   zoom_q, esc_q;

	logic              res_valid_q;
	logic [PIX_W-1:0]  out_col_q, out_row_q;
	logic [ITER_W-1:0] iter_q;

	logic              pix_acc, out_free, res_load, done, escape;
	logic [QW-1:0]     quo_col, quo_row;
	logic signed [MW-1:0] m_col, m_row;
	q_word_t           m_col_sat, m_row_sat, a_re, a_im;
	prod_t             p_rr, p_ii, p_ri, diff;
	logic [PROD_W-1:0] mag, bound;
	q_word_t           map_re, map_im, upd_re, upd_im;
	logic [CW-1:0]     n_ext;
	logic [ITER_W-1:0] iter_val;

	assign pix.ready = (state_q == ST_IDLE);
	assign pix_acc   = pix.valid & pix.ready;
	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_re_q   <= '0;
			c_im_q   <= '0;
			zoom_q   <= ZOOM_RST;
			pan_re_q <= '0;
			pan_im_q <= '0;
			esc_q    <= ESC_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_C_RE:      c_re_q   <= cfg.data;
				REG_C_IM:      c_im_q   <= cfg.data;
				REG_ZOOM:      zoom_q   <= cfg.data[UQ_W-1:0];
				REG_PAN_RE:    pan_re_q <= cfg.data;
				REG_PAN_IM:    pan_im_q <= cfg.data;
				REG_ESC_LIMIT: esc_q    <= cfg.data[UQ_W-1:0];
				default: ;
			endcase
		end
	end

	// pixel capture
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			col_q <= pix.pix_col;
			row_q <= pix.pix_row;
		end
	end

	// position to Q4.28: floor(pos * 2^30 / size)
	jet_div #(.DIVISOR(IMG_WIDTH), .PW(PIX_W), .QW(QW)) u_div_col (
		.clk  (clk),
		.load (pix_acc),
		.step (state_q == ST_DIV),
		.pos  (pix.pix_col),
		.quo  (quo_col)
	);

	jet_div #(.DIVISOR(IMG_HEIGHT), .PW(PIX_W), .QW(QW)) u_div_row (
		.clk  (clk),
		.load (pix_acc),
		.step (state_q == ST_DIV),
		.pos  (pix.pix_row),
		.quo  (quo_row)
	);

	// center on zero and clamp to 32 bits
	assign m_col     = $signed({1'b0, quo_col}) - $signed(MW'(MAP_HALF));
	assign m_row     = $signed({1'b0, quo_row}) - $signed(MW'(MAP_HALF));
	assign m_col_sat = sat32(SAT_W'(m_col));
	assign m_row_sat = sat32(SAT_W'(m_row));

	// shared multiplier bank
	assign a_re = (state_q == ST_MAP_MUL) ? m_col_sat : zr_q;
	assign a_im = (state_q == ST_MAP_MUL) ? m_row_sat : zi_q;

	jet_cmul u_cmul (
		.clk     (clk),
		.map_sel (state_q == ST_MAP_MUL),
		.a_re    (a_re),
		.a_im    (a_im),
		.k       (zoom_q),
		.p_rr    (p_rr),
		.p_ii    (p_ii),
		.p_ri    (p_ri)
	);

	// start point: floor(m * zoom / 2^28) + pan
	assign map_re = sat32(SAT_W'($signed(p_rr[PROD_W-1:FRAC])) + SAT_W'(pan_re_q));
	assign map_im = sat32(SAT_W'($signed(p_ii[PROD_W-1:FRAC])) + SAT_W'(pan_im_q));

	// escape test and z^2 + c
	assign mag    = $unsigned(p_rr) + $unsigned(p_ii);
	assign bound  = {5'd0, esc_q, 28'd0};
	assign escape = (mag > bound);
	assign done   = (n_q == NW'(ITER_CAP)) || escape;
	assign diff   = p_rr - p_ii;
	assign upd_re = sat32(SAT_W'($signed(diff[PROD_W-1:FRAC])) + SAT_W'(c_re_q));
	assign upd_im = sat32(SAT_W'($signed(p_ri[PROD_W-1:FRAC-1])) + SAT_W'(c_im_q));

	assign out_free = !res_valid_q || res.ready;
	assign res_load = (state_q == ST_UPD) && done && out_free;

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (pix_acc) state_d = ST_DIV;
			ST_DIV:     state_d = ST_MAP_MUL;
			ST_MAP_MUL: state_d = ST_MAP_ADD;
			ST_MAP_ADD: state_d = ST_MUL;
			ST_MUL:     state_d = ST_UPD;
			ST_UPD: begin
				if (!done) begin
					state_d = ST_MUL;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// state and iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MAP_ADD) begin
				n_q <= '0;
			end else if (state_q == ST_UPD && !done) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	// z register
	always_ff @(posedge clk) begin
		if (state_q == ST_MAP_ADD) begin
			zr_q <= map_re;
			zi_q <= map_im;
		end else if (state_q == ST_UPD && !done) begin
			zr_q <= upd_re;
			zi_q <= upd_im;
		end
	end

	// count clamps to the field
	assign n_ext    = CW'(n_q);
	assign iter_val = (n_ext > CW'(ITER_MAX)) ? ITER_W'(ITER_MAX) : n_ext[ITER_W-1:0];

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_col_q <= col_q;
			out_row_q <= row_q;
			iter_q    <= iter_val;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.out_col    = out_col_q;
	assign res.out_row    = out_row_q;
	assign res.iter_count = iter_q;

endmodule

`default_nettype wire

/* hw/rtl/jet_chk.sv */
// Port-level checker for julia_escape_time, bound to the top level below.
// Depends on jet_pkg and julia_escape_time_assert.svh.
`default_nettype none
`include "julia_escape_time_assert.svh"

module jet_chk import jet_pkg::*; #(
	parameter int ITER_CAP = DEF_ITER_CAP
) (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [ITER_W-1:0] res_iter
);

	localparam int CAP_LIM = (ITER_CAP > ITER_MAX) ? ITER_MAX : ITER_CAP;

	// result word holds until taken
	`JET_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result word dropped")

	// engine goes busy once a pixel word is taken
	`JET_ASSERT_NXT(a_busy, pix_valid && pix_ready, !pix_ready ##1 !pix_ready, "ready while busy")

	// count never passes the iteration cap
	`JET_ASSERT_IMP(a_cap, res_valid, res_iter <= ITER_W'(CAP_LIM), "count beyond cap")

	// a new result comes only out of a busy engine
	`JET_ASSERT_IMP(a_res_src, $rose(res_valid), $past(!pix_ready), "result while idle")

endmodule

bind julia_escape_time jet_chk #(.ITER_CAP(ITER_CAP)) u_jet_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_iter  (res.iter_count)
);

`default_nettype wire
